// ----- hw/rtl/stcb_pkg.sv -----
`default_nettype none

package stcb_pkg;

   localparam int COLS   = 21;
   localparam int ROWS   = 8;
   localparam int CELLS  = ROWS * COLS;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int COL_W  = (COLS > 1) ? $clog2(COLS) : 1;
   localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int CHAR_W = 8;

   localparam logic [ROW_W-1:0]  LAST_ROW = ROW_W'(ROWS - 1);
   localparam logic [COL_W-1:0]  LAST_COL = COL_W'(COLS - 1);
   localparam logic [ROW_W:0]    ROWS_X   = (ROW_W + 1)'(ROWS);
   localparam logic [ADDR_W-1:0] COLS_A   = ADDR_W'(COLS);

   localparam logic [CHAR_W-1:0] CHAR_BLANK = 8'd32;
   localparam logic [CHAR_W-1:0] CODE_BS    = 8'd8;
   localparam logic [CHAR_W-1:0] CODE_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_CR    = 8'd13;

   localparam logic FUNC_PUT  = 1'b0;
   localparam logic FUNC_READ = 1'b1;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRITE,
      ST_SWEEP,
      ST_READ,
      ST_RESP
   } state_type;

endpackage

`default_nettype wire

// ----- hw/rtl/stcb_ram.sv -----
`default_nettype none

module stcb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/stcb_agen.sv -----
`default_nettype none

module stcb_agen import stcb_pkg::*; (
   input  wire logic [ROW_W-1:0]  base,
   input  wire logic [ROW_W-1:0]  log_row,
   input  wire logic [COL_W-1:0]  col,
   output logic      [ADDR_W-1:0] addr
);

   logic [ROW_W:0]   row_sum;
   logic [ROW_W-1:0] phys_row;

   // The top of the screen sits at physical row base; rows wrap around.
   always_comb begin
      row_sum = {1'b0, log_row} + {1'b0, base};
      if (row_sum >= ROWS_X) begin
         phys_row = ROW_W'(row_sum - ROWS_X);
      end else begin
         phys_row = row_sum[ROW_W-1:0];
      end
      addr = ADDR_W'(phys_row) * COLS_A + ADDR_W'(col);
   end

endmodule

`default_nettype wire

// ----- hw/rtl/scrolling_text_console_buffer.sv -----
`default_nettype none

// Channel   Direction  Handshake              Words
// req_*     in         req_valid/req_ready    func, char_code, cell_row, cell_col
// rsp_*     out        rsp_valid/rsp_ready    cell_char, cursor_pos, scrolled
//
// A read word, a carriage return or a backspace at column 0 runs ST_READ and
// ST_RESP; a stored character or another backspace runs ST_WRITE first, a line
// feed ST_SWEEP first and a character that fills the bottom row ST_WRITE and
// ST_SWEEP first. A scroll clears the new bottom row through the single write
// port of the cell memory, one cell per cycle.
// After reset the block sweeps all ROWS*COLS = 168 cells to spaces, one per
// cycle, and holds req_ready low until the sweep is done.
// A finished word waits in the output register; a new request is taken
// meanwhile, and only its final hand-off stalls until rsp_ready.

module scrolling_text_console_buffer import stcb_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic        req_func,
   input  wire logic [7:0]  req_char_code,
   input  wire logic [2:0]  req_cell_row,
   input  wire logic [4:0]  req_cell_col,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic      [7:0]  rsp_cell_char,
   output logic      [4:0]  rsp_cursor_pos,
   output logic             rsp_scrolled
);

   state_type         state_ff, state_in;
   logic [ROW_W-1:0]  base_ff, base_in;
   logic [COL_W-1:0]  cursor_ff, cursor_in;
   logic [ROW_W-1:0]  sweep_row_ff, sweep_row_in;
   logic [COL_W-1:0]  sweep_col_ff, sweep_col_in;
   logic [2:0]        row_ff, row_in;
   logic [4:0]        col_ff, col_in;
   logic [CHAR_W-1:0] wr_data_ff, wr_data_in;
   logic              adv_ff, adv_in;
   logic              scrolled_ff, scrolled_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [7:0]        rsp_char_ff, rsp_char_in;
   logic [4:0]        rsp_cursor_ff, rsp_cursor_in;
   logic              rsp_scrolled_ff, rsp_scrolled_in;

   logic [ROW_W-1:0]  ag_row;
   logic [COL_W-1:0]  ag_col;
   logic [ADDR_W-1:0] ag_addr;
   logic              ram_we;
   logic [CHAR_W-1:0] ram_wdata;
   logic              ram_re;
   logic [CHAR_W-1:0] ram_rdata;
   logic              cell_ok;
   logic [ROW_W-1:0]  base_next;

   stcb_agen u_agen (
      .base    (base_ff),
      .log_row (ag_row),
      .col     (ag_col),
      .addr    (ag_addr)
   );

   stcb_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (CELLS)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ag_addr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ag_addr),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         base_ff      <= '0;
         cursor_ff    <= '0;
         sweep_row_ff <= '0;
         sweep_col_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         base_ff      <= base_in;
         cursor_ff    <= cursor_in;
         sweep_row_ff <= sweep_row_in;
         sweep_col_ff <= sweep_col_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      row_ff          <= row_in;
      col_ff          <= col_in;
      wr_data_ff      <= wr_data_in;
      adv_ff          <= adv_in;
      scrolled_ff     <= scrolled_in;
      rsp_char_ff     <= rsp_char_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   always_comb begin
      state_in        = state_ff;
      base_in         = base_ff;
      cursor_in       = cursor_ff;
      sweep_row_in    = sweep_row_ff;
      sweep_col_in    = sweep_col_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      wr_data_in      = wr_data_ff;
      adv_in          = adv_ff;
      scrolled_in     = scrolled_ff;
      rsp_char_in     = rsp_char_ff;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      req_ready       = 1'b0;
      ram_we          = 1'b0;
      ram_re          = 1'b0;
      ram_wdata       = CHAR_BLANK;
      ag_row          = LAST_ROW;
      ag_col          = cursor_ff;
      base_next       = (base_ff == LAST_ROW) ? '0 : base_ff + 1'b1;
      cell_ok         = (int'(row_ff) < ROWS) && (int'(col_ff) < COLS);

      unique case (state_ff)
         ST_CLEAR: begin
            ag_row = sweep_row_ff;
            ag_col = sweep_col_ff;
            ram_we = 1'b1;
            if (sweep_col_ff == LAST_COL) begin
               sweep_col_in = '0;
               if (sweep_row_ff == LAST_ROW) begin
                  sweep_row_in = '0;
                  state_in     = ST_IDLE;
               end else begin
                  sweep_row_in = sweep_row_ff + 1'b1;
               end
            end else begin
               sweep_col_in = sweep_col_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               row_in      = req_cell_row;
               col_in      = req_cell_col;
               scrolled_in = 1'b0;
               adv_in      = 1'b0;
               wr_data_in  = CHAR_BLANK;
               state_in    = ST_READ;
               if (req_func == FUNC_PUT) begin
                  priority if (req_char_code == CODE_BS) begin
                     if (cursor_ff != '0) begin
                        cursor_in = cursor_ff - 1'b1;
                        state_in  = ST_WRITE;
                     end
                  end else if (req_char_code == CODE_CR) begin
                     state_in = ST_READ;
                  end else if (req_char_code == CODE_LF) begin
                     base_in      = base_next;
                     cursor_in    = '0;
                     scrolled_in  = 1'b1;
                     sweep_col_in = '0;
                     state_in     = ST_SWEEP;
                  end else begin
                     wr_data_in = req_char_code;
                     adv_in     = 1'b1;
                     state_in   = ST_WRITE;
                  end
               end
            end
         end
         ST_WRITE: begin
            ram_we    = 1'b1;
            ram_wdata = wr_data_ff;
            state_in  = ST_READ;
            if (adv_ff) begin
               if (cursor_ff == LAST_COL) begin
                  base_in      = base_next;
                  cursor_in    = '0;
                  scrolled_in  = 1'b1;
                  sweep_col_in = '0;
                  state_in     = ST_SWEEP;
               end else begin
                  cursor_in = cursor_ff + 1'b1;
               end
            end
         end
         ST_SWEEP: begin
            ag_col = sweep_col_ff;
            ram_we = 1'b1;
            if (sweep_col_ff == LAST_COL) begin
               sweep_col_in = '0;
               state_in     = ST_READ;
            end else begin
               sweep_col_in = sweep_col_ff + 1'b1;
            end
         end
         ST_READ: begin
            ag_row   = ROW_W'(row_ff);
            ag_col   = COL_W'(col_ff);
            ram_re   = 1'b1;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_char_in     = cell_ok ? ram_rdata : '0;
               rsp_cursor_in   = 5'(cursor_ff);
               rsp_scrolled_in = scrolled_ff;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cursor_pos = rsp_cursor_ff;
   assign rsp_scrolled   = rsp_scrolled_ff;

   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      int'(cursor_ff) < COLS)
      else $error("cursor left the bottom row");

   a_scroll_home: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_scrolled |-> rsp_cursor_pos == '0)
      else $error("scrolled word without cursor at column zero");

   a_base_scroll: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(base_ff) |-> scrolled_ff)
      else $error("row base moved without a scroll");

   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken while one is in work");

endmodule

`default_nettype wire
